>>> design/shcr_pkg.sv
// shared types and constants of the sobel/harris corner response block
// used by shcr_pos_ctr, shcr_resp_math and the top level; no dependencies
package shcr_pkg;

	localparam int RW   = 13;
	localparam int TAPS = 9;

	typedef logic [RW-1:0] row_t;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_K      = 2'd2;

	// neighbor offsets in raster order of the 3x3 window
	localparam logic signed [1:0] NB_DR [TAPS] = '{
		-2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1};
	localparam logic signed [1:0] NB_DC [TAPS] = '{
		-2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd1};

	localparam logic signed [2:0] SOBEL_X [TAPS] = '{
		3'sd1, 3'sd2, 3'sd1, 3'sd0, 3'sd0, 3'sd0, -3'sd1, -3'sd2, -3'sd1};
	localparam logic signed [2:0] SOBEL_Y [TAPS] = '{
		3'sd1, 3'sd0, -3'sd1, 3'sd2, 3'sd0, -3'sd2, 3'sd1, 3'sd0, -3'sd1};

	// log2 of the 1 2 1 / 2 4 2 / 1 2 1 weights
	localparam logic [1:0] WT_SHIFT [TAPS] = '{
		2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0};

	typedef struct packed {
		logic pos_zero;
		logic in_area;
		logic g_ok;
		logic q_ok;
		logic q_in_area;
		logic q_last;
	} shcr_flags_t;

	typedef struct packed {
		logic zero;
		logic adv;
	} shcr_pos_ctl_t;

endpackage

>>> design/shcr_pos_ctr.sv
// raster position tracking: input column/row, delay line write pointer,
// gradient and response centers; depends on shcr_pkg
module shcr_pos_ctr import shcr_pkg::*; #(
	parameter int MAX_WIDTH = 2048,
	localparam int LINE = 2 * MAX_WIDTH + 3,
	localparam int AW = $clog2(LINE),
	localparam int CW = $clog2(MAX_WIDTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  shcr_pos_ctl_t ctl,
	input  logic [CW-1:0] eff_w,
	input  logic [11:0]   eff_h,
	output shcr_flags_t   flags,
	output logic [AW-1:0] wp,
	output logic [AW-1:0] wp_g,
	output row_t          g_row,
	output row_t          q_row,
	output logic [CW-1:0] g_col,
	output logic [CW-1:0] q_col
);

	logic [CW-1:0] pc_q;
	row_t          pr_q;
	logic [AW-1:0] wp_q;
	logic [CW-1:0] w_m1;
	row_t          h_r;

	function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] base,
		input logic [AW:0] sub);
		logic [AW:0] diff;
		diff = {1'b0, base} - sub;
		if (diff[AW])
			return AW'(diff + (AW+1)'(LINE));
		return diff[AW-1:0];
	endfunction

	assign w_m1 = eff_w - CW'(1);
	assign h_r  = RW'(eff_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			pr_q <= '0;
			wp_q <= '0;
		end else if (ctl.zero) begin
			pc_q <= '0;
			pr_q <= '0;
			wp_q <= '0;
		end else if (ctl.adv) begin
			if (pc_q == w_m1) begin
				pc_q <= '0;
				pr_q <= pr_q + RW'(1);
			end else begin
				pc_q <= pc_q + CW'(1);
			end
			wp_q <= (wp_q == AW'(LINE - 1)) ? '0 : wp_q + AW'(1);
		end
	end

	always_comb begin
		g_col = (pc_q == '0) ? w_m1 : pc_q - CW'(1);
		g_row = (pc_q == '0) ? pr_q - RW'(2) : pr_q - RW'(1);
		q_col = (g_col == '0) ? w_m1 : g_col - CW'(1);
		q_row = (g_col == '0) ? g_row - RW'(2) : g_row - RW'(1);
		flags.pos_zero  = (pc_q == '0) && (pr_q == '0);
		flags.in_area   = pr_q < h_r;
		flags.g_ok      = !((pr_q == '0) || ((pr_q == RW'(1)) && (pc_q == '0)));
		flags.q_ok      = flags.g_ok &&
			!((g_row == '0) || ((g_row == RW'(1)) && (g_col == '0)));
		flags.q_in_area = q_row < h_r;
		flags.q_last    = (q_row == h_r - RW'(1)) && (q_col == w_m1);
	end

	assign wp   = wp_q;
	assign wp_g = wrap_sub(wp_q, (AW+1)'(eff_w) + (AW+1)'(1));

endmodule

>>> design/shcr_resp_math.sv
// harris response A*B - C*C - round(k*(A+B)^2 / 2^16), one product per cycle
// depends on shcr_pkg
module shcr_resp_math import shcr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [19:0]        a,
	input  logic [19:0]        b,
	input  logic [19:0]        c,
	input  logic [15:0]        k,
	output logic               done,
	output logic signed [42:0] resp
);

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_AB   = 3'd1;
	localparam logic [2:0] M_CC   = 3'd2;
	localparam logic [2:0] M_TT   = 3'd3;
	localparam logic [2:0] M_KLO  = 3'd4;
	localparam logic [2:0] M_KHI  = 3'd5;
	localparam logic [2:0] M_KT   = 3'd6;
	localparam logic [2:0] M_RES  = 3'd7;

	logic [2:0]  step_q;
	logic        done_q;
	logic [19:0] a_q, b_q, c_q;
	logic [15:0] k_q;
	logic [39:0] ab_q, cc_q;
	logic [41:0] t_q;
	logic [36:0] klo_q, khi_q;
	logic [42:0] kt_q;
	logic signed [42:0] resp_q;
	logic [20:0] s;
	logic [58:0] ksum;
	logic [44:0] rsum;

	assign s    = {1'b0, a_q} + {1'b0, b_q};
	assign ksum = {1'b0, khi_q, 21'b0} + 59'(klo_q) + 59'd32768;
	assign rsum = 45'(ab_q) - 45'(cc_q) - 45'(kt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= M_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (step_q)
				M_IDLE: if (start) step_q <= M_AB;
				M_RES: begin
					step_q <= M_IDLE;
					done_q <= 1'b1;
				end
				default: step_q <= step_q + 3'd1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && step_q == M_IDLE) begin
			a_q <= a;
			b_q <= b;
			c_q <= c;
			k_q <= k;
		end
		if (step_q == M_AB)  ab_q  <= a_q * b_q;
		if (step_q == M_CC)  cc_q  <= c_q * c_q;
		if (step_q == M_TT)  t_q   <= s * s;
		if (step_q == M_KLO) klo_q <= k_q * t_q[20:0];
		if (step_q == M_KHI) khi_q <= k_q * t_q[41:21];
		if (step_q == M_KT)  kt_q  <= ksum[58:16];
		if (step_q == M_RES) resp_q <= $signed(rsum[42:0]);
	end

	assign done = done_q;
	assign resp = resp_q;

endmodule

>>> design/sobel_harris_corner_response_top.sv
// Harris corner response over a raster stream of 8-bit gray pixels with
// 3x3 Sobel gradients (clamped 0..255) and a 1 2 1 weighted 3x3 window.
// The response of pixel q leaves with the item at raster position
// q + 2*W + 2, so 2*W + 2 drain items flush a frame. One item at a time:
// an item that produces a response runs through the gray write, the nine
// neighbor reads of the gray delay line, one gradient write, the nine reads
// of the gradient delay lines, the multiplier sequence and the output load;
// an item with no response ends after the gray write or after the gradient
// write. The delay lines are memories of 2*MAX_WIDTH+3 entries with one read
// and one write port each; no clearing pass is needed.
// depends on shcr_pkg, shcr_pos_ctr, shcr_resp_math
module sobel_harris_corner_response_top import shcr_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [7:0]         pixel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [42:0] response,
	output logic [7:0]         gradient_x,
	output logic [7:0]         gradient_y,
	output logic               end_of_frame
);

	localparam int LINE = 2 * MAX_WIDTH + 3;
	localparam int AW = $clog2(LINE);
	localparam int CW = $clog2(MAX_WIDTH + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GRAD = 3'd1;
	localparam logic [2:0] ST_GWR  = 3'd2;
	localparam logic [2:0] ST_RESP = 3'd3;
	localparam logic [2:0] ST_MATH = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]  state_q;
	logic [3:0]  n_q;
	logic        rv_q;
	logic [3:0]  kp_q;
	logic        out_valid_q;
	logic [11:0] width_q;
	logic [11:0] height_q;
	logic [15:0] k_q;

	logic [7:0] gray_mem [LINE];
	logic [7:0] gx_mem [LINE];
	logic [7:0] gy_mem [LINE];
	logic [7:0] gray_rd_q, gx_rd_q, gy_rd_q;

	logic signed [10:0] sx_q, sy_q;
	logic [19:0] a_q, b_q, c_q;
	logic [7:0]  cgx_q, cgy_q;
	logic signed [42:0] resp_o_q;
	logic [7:0]  gx_o_q, gy_o_q;
	logic        eof_o_q;

	logic [CW-1:0] eff_w;
	logic [11:0]   eff_h;
	shcr_flags_t   flags;
	shcr_pos_ctl_t pctl;
	logic [AW-1:0] wp, wp_g;
	row_t          g_row, q_row, c_row;
	logic [CW-1:0] g_col, q_col, c_col;

	logic [3:0]    k4;
	logic signed [1:0] dr, dc;
	logic [AW:0]   bb, back;
	logic [AW-1:0] base, rd_addr;
	logic          rok, cok, nb_ok;
	logic          acc_in, drop, cfg_we, geo_we, load_out, m_start, m_done;
	logic signed [10:0] tx, ty;
	logic [15:0]   xx, yy, xy;
	logic [42:0]   m_resp;

	function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] b0,
		input logic [AW:0] sub);
		logic [AW:0] diff;
		diff = {1'b0, b0} - sub;
		if (diff[AW])
			return AW'(diff + (AW+1)'(LINE));
		return diff[AW-1:0];
	endfunction

	function automatic logic [7:0] clamp255(input logic signed [10:0] v);
		if (v < 0)
			return 8'd0;
		if (v > 11'sd255)
			return 8'd255;
		return v[7:0];
	endfunction

	// effective geometry
	always_comb begin
		if (width_q == '0)
			eff_w = CW'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH))
			eff_w = CW'(MAX_WIDTH);
		else
			eff_w = CW'(width_q);
		eff_h = (height_q == '0) ? 12'd1 : height_q;
	end

	shcr_pos_ctr #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pctl),
		.eff_w  (eff_w),
		.eff_h  (eff_h),
		.flags  (flags),
		.wp     (wp),
		.wp_g   (wp_g),
		.g_row  (g_row),
		.q_row  (q_row),
		.g_col  (g_col),
		.q_col  (q_col)
	);

	assign m_start = (state_q == ST_MATH) && (n_q == 4'd0);

	shcr_resp_math u_math (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (m_start),
		.a      (a_q),
		.b      (b_q),
		.c      (c_q),
		.k      (k_q),
		.done   (m_done),
		.resp   (m_resp)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign acc_in    = in_valid && in_ready;
	assign drop      = operation && flags.pos_zero;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign geo_we    = cfg_we && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT));
	assign load_out  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		pctl.zero = geo_we ||
			((state_q == ST_GWR) && flags.q_ok && !flags.q_in_area) ||
			(load_out && flags.q_last);
		pctl.adv = (acc_in && !drop && !flags.g_ok) ||
			((state_q == ST_GWR) && !flags.q_ok) ||
			(load_out && !flags.q_last);
	end

	// neighbor address and zero padding check
	always_comb begin
		k4 = (n_q < 4'd9) ? n_q : '0;
		dr = NB_DR[k4];
		dc = NB_DC[k4];
		base  = (state_q == ST_RESP) ? wp_g : wp;
		c_row = (state_q == ST_RESP) ? q_row : g_row;
		c_col = (state_q == ST_RESP) ? q_col : g_col;
		if (dr == -2'sd1)
			bb = ((AW+1)'(eff_w) << 1) + (AW+1)'(1);
		else if (dr == 2'sd0)
			bb = (AW+1)'(eff_w) + (AW+1)'(1);
		else
			bb = (AW+1)'(1);
		if (dc == -2'sd1)
			back = bb + (AW+1)'(1);
		else if (dc == 2'sd1)
			back = bb - (AW+1)'(1);
		else
			back = bb;
		rd_addr = wrap_sub(base, back);
		if (dr == -2'sd1)
			rok = (c_row != '0) && (c_row <= RW'(eff_h));
		else if (dr == 2'sd0)
			rok = c_row < RW'(eff_h);
		else
			rok = (c_row + RW'(1)) < RW'(eff_h);
		if (dc == -2'sd1)
			cok = c_col != '0;
		else if (dc == 2'sd1)
			cok = c_col != (eff_w - CW'(1));
		else
			cok = 1'b1;
		nb_ok = rok && cok;
	end

	always_comb begin
		tx = 11'(SOBEL_X[kp_q]) * $signed({3'b000, gray_rd_q});
		ty = 11'(SOBEL_Y[kp_q]) * $signed({3'b000, gray_rd_q});
		xx = {8'b0, gx_rd_q} * {8'b0, gx_rd_q};
		yy = {8'b0, gy_rd_q} * {8'b0, gy_rd_q};
		xy = {8'b0, gx_rd_q} * {8'b0, gy_rd_q};
	end

	// delay line memories
	always_ff @(posedge clk) begin
		if (acc_in && !drop)
			gray_mem[wp] <= (flags.in_area && !operation) ? pixel : 8'd0;
		gray_rd_q <= gray_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_GWR) begin
			gx_mem[wp_g] <= clamp255(sx_q);
			gy_mem[wp_g] <= clamp255(sy_q);
		end
		gx_rd_q <= gx_mem[rd_addr];
		gy_rd_q <= gy_mem[rd_addr];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			rv_q        <= 1'b0;
			kp_q        <= '0;
			out_valid_q <= 1'b0;
			width_q     <= 12'd640;
			height_q    <= 12'd480;
			k_q         <= 16'd2621;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WIDTH:  width_q  <= cfg_data[11:0];
					CFG_HEIGHT: height_q <= cfg_data[11:0];
					CFG_K:      k_q      <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (load_out)
				out_valid_q <= 1'b1;
			if (n_q < 4'd9) begin
				rv_q <= nb_ok;
				kp_q <= n_q;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in && !drop && flags.g_ok) begin
						state_q <= ST_GRAD;
						n_q     <= '0;
					end
				end
				ST_GRAD: begin
					if (n_q == 4'd9) begin
						state_q <= ST_GWR;
						n_q     <= '0;
					end else begin
						n_q <= n_q + 4'd1;
					end
				end
				ST_GWR: begin
					if (flags.q_ok && flags.q_in_area)
						state_q <= ST_RESP;
					else
						state_q <= ST_IDLE;
				end
				ST_RESP: begin
					if (n_q == 4'd9) begin
						state_q <= ST_MATH;
						n_q     <= '0;
					end else begin
						n_q <= n_q + 4'd1;
					end
				end
				ST_MATH: begin
					if (n_q == 4'd0)
						n_q <= 4'd1;
					if (m_done)
						state_q <= ST_OUT;
				end
				ST_OUT: if (load_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// accumulators and output register
	always_ff @(posedge clk) begin
		if (acc_in) begin
			sx_q <= '0;
			sy_q <= '0;
		end
		if (state_q == ST_GRAD && n_q != '0 && rv_q) begin
			sx_q <= sx_q + tx;
			sy_q <= sy_q + ty;
		end
		if (state_q == ST_GWR) begin
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
		end
		if (state_q == ST_RESP && n_q != '0) begin
			if (rv_q) begin
				a_q <= a_q + (20'(xx) << WT_SHIFT[kp_q]);
				b_q <= b_q + (20'(yy) << WT_SHIFT[kp_q]);
				c_q <= c_q + (20'(xy) << WT_SHIFT[kp_q]);
			end
			if (kp_q == 4'd4) begin
				cgx_q <= gx_rd_q;
				cgy_q <= gy_rd_q;
			end
		end
		if (load_out) begin
			resp_o_q <= m_resp;
			gx_o_q   <= cgx_q;
			gy_o_q   <= cgy_q;
			eof_o_q  <= flags.q_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign response     = resp_o_q;
	assign gradient_x   = gx_o_q;
	assign gradient_y   = gy_o_q;
	assign end_of_frame = eof_o_q;

endmodule

>>> design/shcr_checker.sv
// port-level checks for the corner response block, bound to the top level
// depends on sobel_harris_corner_response_top ports only
module shcr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [15:0] cfg_data,
	input logic        in_valid,
	input logic        in_ready,
	input logic        operation,
	input logic [7:0]  pixel,
	input logic        out_valid,
	input logic        out_ready,
	input logic [42:0] response,
	input logic [7:0]  gradient_x,
	input logic [7:0]  gradient_y,
	input logic        end_of_frame
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(response) &&
		$stable(end_of_frame))
		else $error("stalled result changed");

	// config port never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config request stalled");

	// waiting request holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(operation) &&
		$stable(pixel))
		else $error("waiting request changed");

endmodule

bind sobel_harris_corner_response_top shcr_checker u_shcr_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for sobel_harris_corner_response_top: a scoreboard
// class predicts gradients and corner response per request; tasks drive the ports
// depends on shcr_pkg and the top level of the block only
module testbench;
	import shcr_pkg::*;

	localparam int MAX_W = 2048;
	localparam int LINE_LEN = 2 * MAX_W + 3;
	localparam int SETTLE = 40;
	localparam int STALL_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 1100;
	localparam int WIDE_ITEMS = 200;
	localparam bit OP_PIXEL = 1'b0;
	localparam bit OP_DRAIN = 1'b1;

	typedef struct {
		logic signed [42:0] response;
		logic [7:0]         gx;
		logic [7:0]         gy;
		logic               eof;
	} corner_result_t;

	class corner_scoreboard;
		int unsigned width_reg, height_reg, k_reg, position;
		byte unsigned gray_line[LINE_LEN];
		byte unsigned gx_line[LINE_LEN];
		byte unsigned gy_line[LINE_LEN];
		corner_result_t awaited[$];
		int mismatches, checked, frames, items;

		function new();
			width_reg = 640;
			height_reg = 480;
			k_reg = 2621;
			position = 0;
			mismatches = 0;
			checked = 0;
			frames = 0;
			items = 0;
			foreach (gray_line[i]) begin
				gray_line[i] = 0;
				gx_line[i] = 0;
				gy_line[i] = 0;
			end
		endfunction

		function int unsigned eff_w();
			if (width_reg < 1) return 1;
			if (width_reg > MAX_W) return MAX_W;
			return width_reg;
		endfunction

		function int unsigned eff_h();
			return (height_reg < 1) ? 1 : height_reg;
		endfunction

		function void note_config(logic [1:0] index, logic [15:0] data);
			case (index)
				CFG_WIDTH: begin
					width_reg = data[11:0];
					position = 0;
				end
				CFG_HEIGHT: begin
					height_reg = data[11:0];
					position = 0;
				end
				CFG_K: k_reg = data;
				default: ;
			endcase
		endfunction

		// zero padding: neighbors outside the image are skipped
		function bit tap(int unsigned ctr, int unsigned newest, int dr, int dc,
				int unsigned w, int unsigned h, output int unsigned idx);
			int rr, cc, back;
			rr = int'(ctr / w) + dr;
			cc = int'(ctr % w) + dc;
			idx = 0;
			if (rr < 0 || rr >= int'(h) || cc < 0 || cc >= int'(w)) return 0;
			back = int'(w) + 1 - dr * int'(w) - dc;
			idx = (int'(newest) + LINE_LEN - back) % LINE_LEN;
			return 1;
		endfunction

		function void note_request(bit op, logic [7:0] pix);
			int kx[9] = '{1, 2, 1, 0, 0, 0, -1, -2, -1};
			int ky[9] = '{1, 0, -1, 2, 0, -2, 1, 0, -1};
			longint wt[9] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
			int unsigned w, h, area, pos, wp, g, gi, q, idx;
			longint sx, sy, a, b, c, x, y, resp;
			longint unsigned t, kt;
			corner_result_t r;
			w = eff_w();
			h = eff_h();
			area = w * h;
			pos = position;
			if (op == OP_DRAIN && pos == 0) return;
			items++;
			wp = pos % LINE_LEN;
			gray_line[wp] = (op == OP_PIXEL && pos < area) ? pix : 8'd0;
			if (pos < w + 1) begin
				position = pos + 1;
				return;
			end
			g = pos - (w + 1);
			gi = g % LINE_LEN;
			sx = 0;
			sy = 0;
			for (int n = 0; n < 9; n++)
				if (tap(g, wp, n / 3 - 1, n % 3 - 1, w, h, idx)) begin
					sx += kx[n] * longint'(gray_line[idx]);
					sy += ky[n] * longint'(gray_line[idx]);
				end
			gx_line[gi] = 8'((sx < 0) ? 0 : (sx > 255) ? 255 : sx);
			gy_line[gi] = 8'((sy < 0) ? 0 : (sy > 255) ? 255 : sy);
			if (g < w + 1) begin
				position = pos + 1;
				return;
			end
			q = g - (w + 1);
			if (q >= area) begin
				position = 0;
				return;
			end
			a = 0;
			b = 0;
			c = 0;
			for (int n = 0; n < 9; n++)
				if (tap(q, gi, n / 3 - 1, n % 3 - 1, w, h, idx)) begin
					x = gx_line[idx];
					y = gy_line[idx];
					a += x * x * wt[n];
					b += y * y * wt[n];
					c += x * y * wt[n];
				end
			t = longint'(a + b) * longint'(a + b);
			kt = (longint'(k_reg) * t + 64'd32768) >> 16;
			resp = a * b - c * c - longint'(kt);
			if (resp > 64'sd4398046511103) resp = 64'sd4398046511103;
			if (resp < -64'sd4398046511104) resp = -64'sd4398046511104;
			idx = (gi + LINE_LEN - (w + 1)) % LINE_LEN;
			r.response = resp[42:0];
			r.gx = gx_line[idx];
			r.gy = gy_line[idx];
			r.eof = (q == area - 1);
			awaited.push_back(r);
			position = (q == area - 1) ? 0 : pos + 1;
		endfunction

		task report_mismatch(string what, longint got, longint want);
			$display("mismatch on %s at result %0d: got %0d, expected %0d",
				what, checked, got, want);
			mismatches++;
		endtask

		task check_result(logic signed [42:0] resp, logic [7:0] gx,
				logic [7:0] gy, logic eof);
			corner_result_t e;
			if (awaited.size() == 0) begin
				report_mismatch("unexpected result", resp, 0);
				return;
			end
			e = awaited.pop_front();
			if (resp !== e.response) report_mismatch("response", resp, e.response);
			if (gx !== e.gx) report_mismatch("gradient_x", gx, e.gx);
			if (gy !== e.gy) report_mismatch("gradient_y", gy, e.gy);
			if (eof !== e.eof) report_mismatch("end_of_frame", eof, e.eof);
			if (e.eof) frames++;
			checked++;
		endtask
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = CFG_WIDTH;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               operation = OP_PIXEL;
	logic [7:0]         pixel = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [42:0] response;
	logic [7:0]         gradient_x;
	logic [7:0]         gradient_y;
	logic               end_of_frame;

	corner_scoreboard sb = new();
	bit quiet = 1'b0;
	int idle_cycles = 0;

	sobel_harris_corner_response_top dut (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(response, gradient_x, gradient_y, end_of_frame);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no request accepted for %0d cycles", idle_cycles);
				$display("[sobel_harris_corner_response_top] ERROR");
				$finish;
			end
		end
	end

	function automatic int pick_gap(int longest);
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, longest);
	endfunction

	initial begin
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if ($urandom_range(0, 1)) begin
				out_ready <= 1'b0;
				repeat (pick_gap(60) + 1) @(posedge clk);
			end
		end
	end

	task automatic send_item(bit op, logic [7:0] pix);
		int gap;
		gap = quiet ? 0 : pick_gap(30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pixel <= pix;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(op, pix);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] index, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.note_config(index, data);
	endtask

	task automatic run_frame(bit cut_short);
		int unsigned w, h, area, total, stop, slope;
		bit ramp, op;
		logic [7:0] pix;
		w = sb.eff_w();
		h = sb.eff_h();
		area = w * h;
		total = area + 2 * w + 2;
		stop = cut_short ? $urandom_range(1, total - 1) : total;
		ramp = $urandom_range(0, 1);
		slope = $urandom_range(0, 40);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) send_item(OP_DRAIN, $urandom);
		for (int unsigned i = 0; i < stop; i++) begin
			if (i < area)
				op = ($urandom_range(0, 19) == 0);
			else
				op = ($urandom_range(0, 9) != 0);
			pix = ramp ? 8'((i % w) * slope + (i / w) * 5 + $urandom_range(0, 7)) : 8'($urandom);
			send_item(op, pix);
		end
	endtask

	function automatic logic [15:0] pick_k();
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'd2621;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned wv, hv;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small frame with the default k: ignored drain, drain inside the
		// image, pixel past the image, extreme pixel values
		quiet = 1'b1;
		write_reg(CFG_WIDTH, 16'd3);
		write_reg(CFG_HEIGHT, 16'd2);
		cfg_valid <= 1'b0;
		send_item(OP_DRAIN, 8'hFF);
		send_item(OP_PIXEL, 8'hFF);
		send_item(OP_PIXEL, 8'h00);
		send_item(OP_DRAIN, 8'hFF);
		send_item(OP_PIXEL, 8'hFF);
		send_item(OP_PIXEL, 8'h00);
		send_item(OP_PIXEL, 8'hFF);
		repeat (3) send_item(OP_DRAIN, 8'h00);
		send_item(OP_PIXEL, 8'hFF);
		repeat (4) send_item(OP_DRAIN, 8'h00);
		settle();

		// single pixel frame with the largest k
		write_reg(CFG_K, 16'hFFFF);
		write_reg(CFG_WIDTH, 16'd1);
		write_reg(CFG_HEIGHT, 16'd1);
		cfg_valid <= 1'b0;
		send_item(OP_PIXEL, 8'hFF);
		repeat (4) send_item(OP_DRAIN, 8'h00);

		while (sb.items < RANDOM_ITEMS) begin
			settle();
			quiet = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 19))
				0: wv = 0;
				1, 2, 3, 4: wv = $urandom_range(9, 48);
				default: wv = $urandom_range(1, 8);
			endcase
			hv = (wv > 8) ? $urandom_range(1, 3) : $urandom_range(0, 6);
			if ($urandom_range(0, 1)) write_reg(CFG_K, pick_k());
			write_reg(CFG_WIDTH, {4'($urandom), 12'(wv)});
			write_reg(CFG_HEIGHT, {4'($urandom), 12'(hv)});
			cfg_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 9) == 0) begin
					run_frame(1'b1);
					break;
				end
				run_frame(1'b0);
			end
		end

		// oversized width clamped to the widest row, zero height: a partial
		// row that stays short of any result
		settle();
		quiet = 1'b0;
		write_reg(CFG_WIDTH, 16'h0FFF);
		write_reg(CFG_HEIGHT, 16'd0);
		write_reg(CFG_K, pick_k());
		cfg_valid <= 1'b0;
		repeat (WIDE_ITEMS) send_item($urandom_range(0, 1), $urandom);
		settle();

		$display("run covered %0d requests and %0d responses over %0d full frames,",
			sb.items, sb.checked, sb.frames);
		$display("with widths 1..48, clamped geometry and a partial 2048 wide row");
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("[sobel_harris_corner_response_top] OK");
		else
			$display("[sobel_harris_corner_response_top] ERROR");
		$finish;
	end
endmodule

>>> filelist.f
design/shcr_pkg.sv
design/shcr_pos_ctr.sv
design/shcr_resp_math.sv
design/sobel_harris_corner_response_top.sv
design/shcr_checker.sv
sim/testbench.sv
